// ----- rtl/core/trm_pkg.sv -----
package trm_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MEM_BASE   = 16384;
  localparam int unsigned PROG_DEPTH = 1024;

  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_MOVE = 8'd1;
  localparam logic [7:0] OP_ADD  = 8'd2;
  localparam logic [7:0] OP_SUB  = 8'd3;
  localparam logic [7:0] OP_MUL  = 8'd4;
  localparam logic [7:0] OP_DIV  = 8'd5;
  localparam logic [7:0] OP_AND  = 8'd6;
  localparam logic [7:0] OP_OR   = 8'd7;
  localparam logic [7:0] OP_NOT  = 8'd8;
  localparam logic [7:0] OP_CMP  = 8'd9;
  localparam logic [7:0] OP_JMP  = 8'd10;
  localparam logic [7:0] OP_IN   = 8'd11;
  localparam logic [7:0] OP_OUT  = 8'd12;
  localparam logic [7:0] OP_LAST = 8'd15;

  localparam logic [2:0] E_OK   = 3'd0;
  localparam logic [2:0] E_OPC  = 3'd1;
  localparam logic [2:0] E_REG  = 3'd2;
  localparam logic [2:0] E_ADDR = 3'd3;
  localparam logic [2:0] E_DIV  = 3'd4;

  localparam logic [1:0] FLAG_EQ = 2'b00;
  localparam logic [1:0] FLAG_GT = 2'b01;
  localparam logic [1:0] FLAG_LT = 2'b11;

  localparam logic [3:0] COND_ALWAYS = 4'd0;
  localparam logic [3:0] COND_EQ     = 4'd1;
  localparam logic [3:0] COND_GT     = 4'd2;
  localparam logic [3:0] COND_LT     = 4'd3;

  typedef struct packed {
    logic              start;
    logic              is_signed;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/trm_ram.sv -----
module trm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/trm_div.sv -----
module trm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  trm_pkg::div_req_t req,
  output trm_pkg::div_rsp_t rsp
);
  import trm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t            state_r;
  logic [5:0]        cnt_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] dsr_r;
  logic              neg_r;
  logic              done_r;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] rem_shift;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_shift = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
  assign trial     = {1'b0, rem_shift} - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            quo_r   <= (req.is_signed && req.dividend[WORD_W-1]) ?
                       (~req.dividend + 1'b1) : req.dividend;
            dsr_r   <= (req.is_signed && req.divisor[WORD_W-1]) ?
                       (~req.divisor + 1'b1) : req.divisor;
            neg_r   <= req.is_signed && (req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1]);
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (!trial[WORD_W]) begin
            rem_r <= trial[WORD_W-1:0];
            quo_r <= {quo_r[WORD_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_shift;
            quo_r <= {quo_r[WORD_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(WORD_W - 1)) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          if (neg_r) begin
            quo_r <= ~quo_r + 1'b1;
          end
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef SYNTHESIS
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |=> done_r)
    else $error("divider done missing after fix step");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |=> (state_r == S_RUN || state_r == S_FIX))
    else $error("divider left run early");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held");
`endif

endmodule

// ----- rtl/core/toy_register_machine_execute_core.sv -----
// Execute core of a small register machine: one decoded instruction per item.
// Input channel: in_valid/in_stall with in_opcode, in_dst_reg, in_src_sel,
// in_immediate and in_read_value. Result channel: out_valid/out_stall with
// out_next_pc, out_out_valid, out_out_value, out_halted, out_error_code and
// out_compare_flag; every item yields exactly one result.
// An item runs through a small sequencer: register read, address check, data
// memory read (one port of the data RAM, registered read), execute in one
// shared arithmetic unit (a divide by a nonzero operand runs in the radix-2
// divider instead), then writeback; the result is registered. in_stall is
// high while an item is in flight, so a new item is accepted only once the
// last one has left execute or the divider.
// After reset a clearing pass writes zero to every data memory word, one
// word a cycle, while in_stall stays high. Registers, flag, program counter
// and halt flag clear at once.
// The result sits in an output register; while out_stall is high it holds
// and the next item is accepted, then waits in execute until the register
// frees.
module toy_register_machine_execute_core #(
  parameter int unsigned DATA_DEPTH = 2048,
  parameter int unsigned REG_COUNT  = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_opcode,
  input  logic [3:0]               in_dst_reg,
  input  logic [3:0]               in_src_sel,
  input  logic signed [15:0]       in_immediate,
  input  logic signed [31:0]       in_read_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [$clog2(trm_pkg::PROG_DEPTH)-1:0] out_next_pc,
  output logic                     out_out_valid,
  output logic signed [31:0]       out_out_value,
  output logic                     out_halted,
  output logic [2:0]               out_error_code,
  output logic signed [1:0]        out_compare_flag
);
  import trm_pkg::*;

  localparam int unsigned AW = $clog2(DATA_DEPTH);
  localparam int unsigned PW = $clog2(PROG_DEPTH);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ADDR, S_MEM, S_EXEC, S_DIV} state_t;

  state_t            state_r;
  logic [CW-1:0]     clr_cnt_r;
  logic [WORD_W-1:0] regs_r [REG_COUNT];
  logic [1:0]        flag_r;
  logic [PW-1:0]     pc_r;
  logic              halt_r;

  logic [7:0]        op_r;
  logic [3:0]        d_r;
  logic [3:0]        s_r;
  logic [15:0]       imm_r;
  logic [WORD_W-1:0] rdv_r;
  logic [WORD_W-1:0] dval_r;
  logic [WORD_W-1:0] sval_r;
  logic [AW-1:0]     addr_r;
  logic [2:0]        err_r;

  logic              ovld_r;
  logic [PW-1:0]     o_pc_r;
  logic              o_ov_r;
  logic [WORD_W-1:0] o_val_r;
  logic              o_halt_r;
  logic [2:0]        o_err_r;
  logic [1:0]        o_flag_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  div_req_t          dreq;
  div_rsp_t          drsp;

  // Decode on the latched item.
  logic use_d, use_s, mem_src, is_load, mv_mem, bad_reg, addr_ok;
  logic [WORD_W-1:0] addr_reg;
  logic [WORD_W:0]   off;
  logic [WORD_W-1:0] half;
  logic [WORD_W-1:0] opnd;
  logic [WORD_W-1:0] alu;
  logic [WORD_W:0]   diff;
  logic [PW-1:0]     pc_inc;
  logic [PW-1:0]     pc_jmp;
  logic [PW-1:0]     npc;
  logic [1:0]        cmp_flag;
  logic [15:0]       imm_q;
  logic              take;
  logic [2:0]        err_x;
  logic              out_free;
  logic              exec_ok;
  logic              res_load;

  always_comb begin
    use_d   = (op_r >= OP_MOVE && op_r <= OP_CMP) || op_r == OP_IN || op_r == OP_OUT;
    use_s   = (op_r >= OP_MOVE && op_r <= OP_CMP) && s_r != 4'd0;
    mem_src = (op_r >= OP_ADD && op_r <= OP_CMP) && s_r != 4'd0;
    if (op_r == OP_NOT && s_r != 4'd0) begin
      use_d = 1'b0;
    end
    is_load = (op_r == OP_MOVE) && s_r != 4'd0 && d_r <= 4'd4 && s_r > 4'd4;
    mv_mem  = (op_r == OP_MOVE) && s_r != 4'd0;
    bad_reg = (use_d && 32'(d_r) >= REG_COUNT) || (use_s && 32'(s_r) >= REG_COUNT);
    addr_reg = (mv_mem && !is_load) ? dval_r : sval_r;
    // (r - 16384) / 2 truncating toward zero.
    off  = {addr_reg[WORD_W-1], addr_reg} - (WORD_W+1)'(MEM_BASE);
    half = off[WORD_W:1] + WORD_W'(off[WORD_W] & off[0]);
    addr_ok = !half[WORD_W-1] && (half < WORD_W'(DATA_DEPTH));
  end

  always_comb begin
    opnd = (s_r == 4'd0) ? {{16{imm_r[15]}}, imm_r} : mem_rdata;
    diff = {dval_r[WORD_W-1], dval_r} - {opnd[WORD_W-1], opnd};
    alu  = '0;
    case (op_r)
      OP_ADD:  alu = dval_r + opnd;
      OP_SUB:  alu = dval_r - opnd;
      OP_MUL:  alu = dval_r * opnd;
      OP_AND:  alu = WORD_W'((dval_r != '0) && (opnd != '0));
      OP_OR:   alu = WORD_W'((dval_r != '0) || (opnd != '0));
      OP_NOT:  alu = WORD_W'((s_r == 4'd0) ? (dval_r == '0) : (mem_rdata == '0));
      OP_MOVE: alu = (s_r == 4'd0) ? {{16{imm_r[15]}}, imm_r} : mem_rdata;
      OP_IN:   alu = rdv_r;
      default: alu = '0;
    endcase
    take = (s_r == COND_ALWAYS) || (s_r == COND_EQ && flag_r == FLAG_EQ) ||
           (s_r == COND_GT && flag_r == FLAG_GT) || (s_r == COND_LT && flag_r == FLAG_LT);
    imm_q  = (imm_r[15] ? (imm_r + 16'd3) : imm_r);
    pc_inc = pc_r + PW'(1);
    pc_jmp = pc_r + PW'({{2{imm_q[15]}}, imm_q[15:2]});
    npc    = pc_inc;
    if (op_r == OP_HALT) begin
      npc = pc_r;
    end else if (op_r == OP_JMP && take) begin
      npc = pc_jmp;
    end
    cmp_flag = diff[WORD_W] ? FLAG_LT : (diff == '0) ? FLAG_EQ : FLAG_GT;
    err_x  = err_r;
    if (err_r == E_OK && op_r == OP_DIV && opnd == '0) begin
      err_x = E_DIV;
    end
  end

  assign out_free = !ovld_r || !out_stall;
  // A halted machine does not execute the item; it still yields a result.
  assign exec_ok  = !halt_r && err_x == E_OK;

  assign mem_we    = (state_r == S_CLEAR) ||
                     (state_r == S_EXEC && out_free && exec_ok &&
                      ((mv_mem && !is_load) || (op_r == OP_NOT && s_r != 4'd0)));
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r[AW-1:0] : addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 :
                     (op_r == OP_NOT) ? alu : sval_r;

  trm_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign dreq.start     = (state_r == S_EXEC) && out_free && op_r == OP_DIV && exec_ok;
  assign dreq.is_signed = 1'b1;
  assign dreq.dividend  = dval_r;
  assign dreq.divisor   = opnd;

  trm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign res_load = (state_r == S_EXEC && out_free && !dreq.start) ||
                    (state_r == S_DIV && drsp.done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      flag_r    <= FLAG_EQ;
      pc_r      <= '0;
      halt_r    <= 1'b0;
      ovld_r    <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (res_load) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + CW'(1);
          if (clr_cnt_r == CW'(DATA_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            d_r     <= in_dst_reg;
            s_r     <= in_src_sel;
            imm_r   <= in_immediate;
            rdv_r   <= in_read_value;
            dval_r  <= (32'(in_dst_reg) < REG_COUNT) ? regs_r[in_dst_reg] : '0;
            sval_r  <= (32'(in_src_sel) < REG_COUNT) ? regs_r[in_src_sel] : '0;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr_r <= half[AW-1:0];
          if (halt_r) begin
            err_r <= E_OK;
          end else if (op_r > OP_LAST) begin
            err_r <= E_OPC;
          end else if (bad_reg) begin
            err_r <= E_REG;
          end else if ((mv_mem || mem_src) && !addr_ok) begin
            err_r <= E_ADDR;
          end else begin
            err_r <= E_OK;
          end
          state_r <= S_MEM;
        end
        S_MEM: state_r <= S_EXEC;
        S_EXEC: begin
          if (out_free) begin
            if (dreq.start) begin
              state_r <= S_DIV;
            end else begin
              o_ov_r  <= exec_ok && op_r == OP_OUT;
              o_val_r <= (exec_ok && op_r == OP_OUT) ? dval_r : '0;
              o_err_r <= halt_r ? E_OK : err_x;
              if (exec_ok) begin
                pc_r   <= npc;
                o_pc_r <= npc;
                case (op_r)
                  OP_HALT: halt_r <= 1'b1;
                  OP_MOVE: if (s_r == 4'd0 || is_load) regs_r[d_r] <= alu;
                  OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_IN: regs_r[d_r] <= alu;
                  OP_NOT: if (s_r == 4'd0) regs_r[d_r] <= alu;
                  OP_CMP: flag_r <= cmp_flag;
                  default: ;
                endcase
                o_halt_r <= halt_r || op_r == OP_HALT;
                o_flag_r <= (op_r == OP_CMP) ? cmp_flag : flag_r;
              end else begin
                o_pc_r   <= pc_r;
                o_halt_r <= halt_r;
                o_flag_r <= flag_r;
              end
              state_r <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            regs_r[d_r] <= drsp.quotient;
            pc_r     <= pc_inc;
            o_pc_r   <= pc_inc;
            o_ov_r   <= 1'b0;
            o_val_r  <= '0;
            o_halt_r <= halt_r;
            o_err_r  <= E_OK;
            o_flag_r <= flag_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = ovld_r;
  assign out_next_pc      = o_pc_r;
  assign out_out_valid    = o_ov_r;
  assign out_out_value    = o_val_r;
  assign out_halted       = o_halt_r;
  assign out_error_code   = o_err_r;
  assign out_compare_flag = o_flag_r;

`ifndef SYNTHESIS
  a_div_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !ovld_r)
    else $error("divide entered with busy output");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");
  a_result_err_state: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(ovld_r) && o_err_r != E_OK) |-> $stable(pc_r))
    else $error("pc moved on error");
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("item accepted during clear");
`endif

endmodule

// ----- verif/toy_register_machine_execute_core_tb.sv -----
module toy_register_machine_execute_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trm_pkg::*;

  localparam int DATA_DEPTH = 2048;
  localparam int PROG_DEPTH = 1024;
  localparam int REG_COUNT  = 9;
  localparam int NUM_RANDOM = 1880;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]         opcode;
    logic [3:0]         dst_reg;
    logic [3:0]         src_sel;
    logic signed [15:0] immediate;
    logic signed [31:0] read_value;
  } instr_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               emit;
    logic signed [31:0] emit_value;
    logic               halted;
    logic [2:0]         error_code;
    logic signed [1:0]  flag;
  } retire_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [7:0] in_opcode;
  logic [3:0] in_dst_reg, in_src_sel;
  logic signed [15:0] in_immediate;
  logic signed [31:0] in_read_value;
  logic [9:0] out_next_pc;
  logic out_out_valid, out_halted;
  logic signed [31:0] out_out_value;
  logic [2:0] out_error_code;
  logic signed [1:0] out_compare_flag;

  toy_register_machine_execute_core dut (.*);

  // Machine state mirrored by the predictor.
  logic [31:0] gpr [REG_COUNT];
  logic [31:0] dmem [DATA_DEPTH];
  logic [1:0]  flag_q;
  logic [9:0]  pc_q;
  logic        halt_q;

  instr_t  pending_instrs[$];
  retire_t expected_retires[$];
  int      mismatch_count;
  int      idle_cycles;
  bit      quiet_phase;
  bit      stimulus_done;

  function automatic bit word_index(input logic [31:0] r, output int idx);
    longint v;
    v = (longint'($signed(r)) - longint'(MEM_BASE)) / 2;
    idx = int'(v);
    return v >= 0 && v < DATA_DEPTH;
  endfunction

  function automatic retire_t execute_instr(input instr_t it);
    retire_t res;
    logic [7:0] op;
    int d, s, ia, ib;
    bit use_d, use_s, mem_src, take;
    logic [2:0] err;
    logic [31:0] opnd, npc;
    longint a, b;
    op = it.opcode; d = it.dst_reg; s = it.src_sel;
    err = E_OK; opnd = 0; ia = 0; ib = 0;
    res = '0;
    if (!halt_q) begin
      use_d = (op >= OP_MOVE && op <= OP_CMP) || op == OP_IN || op == OP_OUT;
      use_s = (op >= OP_MOVE && op <= OP_CMP) && s != 0;
      mem_src = (op >= OP_ADD && op <= OP_CMP) && s != 0;
      if (op == OP_NOT && s != 0) use_d = 0;
      if (op > OP_LAST) err = E_OPC;
      else if ((use_d && d >= REG_COUNT) || (use_s && s >= REG_COUNT)) err = E_REG;
      else if (op == OP_MOVE && s != 0) begin
        if (d <= 4 && s > 4) begin
          if (!word_index(gpr[s], ia)) err = E_ADDR;
        end else if (!word_index(gpr[d], ia)) err = E_ADDR;
      end else if (mem_src) begin
        if (!word_index(gpr[s], ib)) err = E_ADDR;
      end
      if (err == E_OK && op >= OP_ADD && op <= OP_CMP)
        opnd = (s == 0) ? 32'($signed(it.immediate)) : dmem[ib];
      if (err == E_OK && op == OP_DIV && opnd == 0) err = E_DIV;
      if (err == E_OK) begin
        npc = (pc_q + 1) % PROG_DEPTH;
        case (op)
          OP_HALT: begin
            halt_q = 1;
            npc = pc_q;
          end
          OP_MOVE: begin
            if (s == 0) gpr[d] = 32'($signed(it.immediate));
            else if (d <= 4 && s > 4) gpr[d] = dmem[ia];
            else dmem[ia] = gpr[s];
          end
          OP_ADD: gpr[d] = gpr[d] + opnd;
          OP_SUB: gpr[d] = gpr[d] - opnd;
          OP_MUL: gpr[d] = gpr[d] * opnd;
          OP_DIV: begin
            // The one overflowing quotient wraps back to the most negative value.
            if (gpr[d] == 32'h8000_0000 && opnd == '1) gpr[d] = 32'h8000_0000;
            else gpr[d] = $signed(gpr[d]) / $signed(opnd);
          end
          OP_AND: gpr[d] = (gpr[d] != 0 && opnd != 0);
          OP_OR:  gpr[d] = (gpr[d] != 0 || opnd != 0);
          OP_NOT: begin
            if (s == 0) gpr[d] = (gpr[d] == 0);
            else dmem[ib] = (dmem[ib] == 0);
          end
          OP_CMP: begin
            a = $signed(gpr[d]);
            b = $signed(opnd);
            flag_q = (a == b) ? FLAG_EQ : (a > b ? FLAG_GT : FLAG_LT);
          end
          OP_JMP: begin
            take = s == COND_ALWAYS || (s == COND_EQ && flag_q == FLAG_EQ) ||
                   (s == COND_GT && flag_q == FLAG_GT) ||
                   (s == COND_LT && flag_q == FLAG_LT);
            if (take) begin
              a = (longint'(pc_q) + longint'(it.immediate) / 4) % PROG_DEPTH;
              if (a < 0) a += PROG_DEPTH;
              npc = 32'(a);
            end
          end
          OP_IN: gpr[d] = it.read_value;
          OP_OUT: begin
            res.emit = 1;
            res.emit_value = gpr[d];
          end
          default: ;
        endcase
        pc_q = npc[9:0];
      end
    end
    res.next_pc = pc_q;
    res.halted = halt_q;
    res.error_code = err;
    res.flag = flag_q;
    return res;
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    int r;
    it.opcode = 8'($urandom_range(1, 15));
    r = $urandom_range(0, 99);
    if (r < 2) it.opcode = 8'($urandom_range(16, 255));
    it.dst_reg = (r > 95) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    it.src_sel = ($urandom_range(0, 2) == 0) ? 4'd0 :
                 (r > 93 ? 4'($urandom) : 4'($urandom_range(1, 8)));
    it.immediate = 16'($urandom);
    it.read_value = 32'($urandom);
    // Load pointer-like values so memory operands usually stay in range.
    if (it.opcode == OP_IN && r < 60)
      it.read_value = MEM_BASE + $urandom_range(0, 2 * DATA_DEPTH + 2) - 1;
    return it;
  endfunction

  function automatic instr_t mk(input logic [7:0] op, input int d, input int s,
                                input int imm, input int rv = 0);
    instr_t it;
    it.opcode = op; it.dst_reg = 4'(d); it.src_sel = 4'(s);
    it.immediate = 16'(imm); it.read_value = 32'(rv);
    return it;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    stimulus_done = 0;
    for (int i = 0; i < REG_COUNT; i++) gpr[i] = 0;
    for (int i = 0; i < DATA_DEPTH; i++) dmem[i] = 0;
    flag_q = FLAG_EQ; pc_q = 0; halt_q = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // Directed: every operation, field extremes, each error class, divide overflow.
    pending_instrs.push_back(mk(OP_IN, 5, 0, 0, MEM_BASE));
    pending_instrs.push_back(mk(OP_IN, 6, 0, 0, MEM_BASE + 2 * DATA_DEPTH - 1));
    pending_instrs.push_back(mk(OP_IN, 7, 0, 0, MEM_BASE + 2 * DATA_DEPTH));
    pending_instrs.push_back(mk(OP_MOVE, 1, 0, -32768));
    pending_instrs.push_back(mk(OP_MOVE, 5, 1, 0));
    pending_instrs.push_back(mk(OP_MOVE, 2, 5, 0));
    pending_instrs.push_back(mk(OP_MOVE, 7, 1, 0));
    pending_instrs.push_back(mk(OP_ADD, 2, 6, 32767));
    pending_instrs.push_back(mk(OP_SUB, 1, 0, 1));
    pending_instrs.push_back(mk(OP_MUL, 1, 0, -1));
    pending_instrs.push_back(mk(OP_IN, 3, 0, 0, 32'h8000_0000));
    pending_instrs.push_back(mk(OP_DIV, 3, 0, -1));
    pending_instrs.push_back(mk(OP_DIV, 3, 6, 0));
    pending_instrs.push_back(mk(OP_DIV, 1, 5, 0));
    pending_instrs.push_back(mk(OP_AND, 1, 0, 0));
    pending_instrs.push_back(mk(OP_OR, 1, 5, 0));
    pending_instrs.push_back(mk(OP_NOT, 1, 0, 0));
    pending_instrs.push_back(mk(OP_NOT, 15, 6, 0));
    pending_instrs.push_back(mk(OP_CMP, 3, 0, 5));
    pending_instrs.push_back(mk(OP_JMP, 15, COND_LT, -32768));
    pending_instrs.push_back(mk(OP_JMP, 0, 15, 32767));
    pending_instrs.push_back(mk(OP_OUT, 3, 0, 0));
    pending_instrs.push_back(mk(8'd13, 9, 9, 0));
    pending_instrs.push_back(mk(8'd255, 0, 0, 0));
    pending_instrs.push_back(mk(OP_ADD, 12, 0, 0));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      pending_instrs.push_back(rand_instr());
      // Keep the queue short so the halt lands near the end.
      while (pending_instrs.size() > 8) @(posedge clk);
    end
    pending_instrs.push_back(mk(OP_HALT, 0, 0, 0));
    pending_instrs.push_back(mk(OP_OUT, 1, 0, 0));
    pending_instrs.push_back(mk(8'd200, 0, 0, 0));
    while (pending_instrs.size() != 0 || in_valid) @(posedge clk);
    stimulus_done = 1;
  end

  // The middle of the run has a stretch with no idling on either side.
  always @(posedge clk) quiet_phase <= ($time / 20) > 4000 && ($time / 20) < 7000;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_opcode <= '0; in_dst_reg <= '0; in_src_sel <= '0;
      in_immediate <= '0; in_read_value <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending_instrs.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 20)) begin
        instr_t it;
        it = pending_instrs.pop_front();
        in_valid <= 1;
        in_opcode <= it.opcode; in_dst_reg <= it.dst_reg; in_src_sel <= it.src_sel;
        in_immediate <= it.immediate; in_read_value <= it.read_value;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= !quiet_phase && $urandom_range(0, 99) < 20;
  end

  always @(posedge clk) begin
    retire_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_retires.push_back(execute_instr({in_opcode, in_dst_reg, in_src_sel,
                                                  in_immediate, in_read_value}));
      if (out_valid && !out_stall) begin
        got = {out_next_pc, out_out_valid, out_out_value, out_halted,
               out_error_code, out_compare_flag};
        if (expected_retires.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result item %h", got);
        end else begin
          want = expected_retires.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("item mismatch: pc %0d/%0d emit %0b/%0b val %h/%h halt %0b/%0b err %0d/%0d flag %0d/%0d",
                       want.next_pc, got.next_pc, want.emit, got.emit,
                       want.emit_value, got.emit_value, want.halted, got.halted,
                       want.error_code, got.error_code, want.flag, got.flag);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatch_count = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("toy_register_machine_execute_core: mismatch");
        $finish;
      end
      if (stimulus_done && expected_retires.size() == 0) begin
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && expected_retires.size() == 0 && !out_valid)
          $display("toy_register_machine_execute_core: match");
        else
          $display("toy_register_machine_execute_core: mismatch");
        $finish;
      end
    end
  end

endmodule
